FILE: rtl/core/i2cbb_pkg.sv
// Shared types and constants for the I2C byte master.
package i2cbb_pkg;

    localparam int UNIT_W      = 16;
    localparam int RETRY_W     = 8;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int DELAY_W     = 19;

    localparam logic [UNIT_W-1:0]      UNIT_TICKS_RESET  = 16'd300;
    localparam logic [RETRY_W-1:0]     ACK_RETRIES_RESET = 8'd10;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_RETRIES   = 2'd1;

    localparam logic [1:0] CMD_CODE_READ  = 2'd1;
    localparam logic [1:0] CMD_CODE_WRITE = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_READ,
        KIND_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  device_addr;
        logic [BYTE_W-1:0]  register_addr;
        logic [BYTE_W-1:0]  write_data;
        logic               sda_in;
    } tick_word_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4,
        PH_TXB, PH_TXH, PH_TXL,
        PH_AREL, PH_AHI, PH_ASMP, PH_AGIVE,
        PH_RREL, PH_RHI, PH_RSMP, PH_RLO,
        PH_NHI, PH_NLO,
        PH_SP0, PH_SP1, PH_SP2, PH_SP3, PH_SP4,
        PH_ENDOK, PH_ABORT
    } phase_t;

endpackage

FILE: rtl/core/i2c_bitbang_master.sv
// I2C byte master: one bus tick per input word, one status word out per tick.
//
// Input channel (s_*): one word per bus tick carrying an optional command
// (read or write one byte), the addresses, the write byte and the sampled SDA.
// Output channel (m_*): one word per input word with the SCL/SDA levels, the
// SDA drive enable, busy/done/ack_fail status and the last byte read.
// Configuration channel (cfg_*): index 0 sets unit_ticks, index 1 sets
// ack_retries; write only while no command is in progress. cfg_ready is
// always high.
// Throughput: one word per cycle when the output slot is free. Each accepted
// word is written into the two-entry input queue, then registered into the
// sequencer, which retires one word per cycle while the output slot is free.
// A stalled receiver holds the output word; the queue fills and s_ready drops
// after two more words. Reset empties the queue, drops m_valid, returns the
// lines to SCL high, SDA released and restores the default configuration.
module i2c_bitbang_master (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i2cbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cbb_pkg::UNIT_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [i2cbb_pkg::BYTE_W-1:0]      s_device_addr,
    input  logic [i2cbb_pkg::BYTE_W-1:0]      s_register_addr,
    input  logic [i2cbb_pkg::BYTE_W-1:0]      s_write_data,
    input  logic                              s_sda_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_scl_out,
    output logic                              m_sda_out,
    output logic                              m_sda_drive,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic                              m_ack_fail,
    output logic [i2cbb_pkg::BYTE_W-1:0]      m_read_data
);
    import i2cbb_pkg::*;

    logic       q_valid;
    logic       q_pop;
    tick_word_t q_word;

    i2cbb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_device_addr   (s_device_addr),
        .s_register_addr (s_register_addr),
        .s_write_data    (s_write_data),
        .s_sda_in        (s_sda_in),
        .q_valid         (q_valid),
        .q_word          (q_word),
        .q_pop           (q_pop)
    );

    i2cbb_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_sda_drive (m_sda_drive),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_ack_fail  (m_ack_fail),
        .m_read_data (m_read_data)
    );

endmodule

FILE: rtl/core/i2cbb_front.sv
// Front end: accepts tick words, decodes the command and queues them.
module i2cbb_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_command,
    input  logic [i2cbb_pkg::BYTE_W-1:0] s_device_addr,
    input  logic [i2cbb_pkg::BYTE_W-1:0] s_register_addr,
    input  logic [i2cbb_pkg::BYTE_W-1:0] s_write_data,
    input  logic                     s_sda_in,
    output logic                     q_valid,
    output i2cbb_pkg::tick_word_t    q_word,
    input  logic                     q_pop
);
    import i2cbb_pkg::*;

    tick_word_t slot_reg [2];
    tick_word_t in_word;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    always_comb begin
        case (s_command)
            CMD_CODE_READ:  in_word.kind = KIND_READ;
            CMD_CODE_WRITE: in_word.kind = KIND_WRITE;
            default:        in_word.kind = KIND_NONE;
        endcase
        in_word.device_addr   = s_device_addr;
        in_word.register_addr = s_register_addr;
        in_word.write_data    = s_write_data;
        in_word.sda_in        = s_sda_in;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

FILE: rtl/core/i2cbb_engine.sv
// Back end: bus sequencer, one tick word per unstalled cycle, holds the result word.
module i2cbb_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i2cbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cbb_pkg::UNIT_W-1:0]      cfg_data,
    input  logic                              q_valid,
    input  i2cbb_pkg::tick_word_t             q_word,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_scl_out,
    output logic                              m_sda_out,
    output logic                              m_sda_drive,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic                              m_ack_fail,
    output logic [i2cbb_pkg::BYTE_W-1:0]      m_read_data
);
    import i2cbb_pkg::*;

    logic [UNIT_W-1:0]  unit_reg;
    logic [RETRY_W-1:0] retries_reg;

    phase_t             phase_reg, phase_next;
    logic [2:0]         bit_reg, bit_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [RETRY_W-1:0] poll_reg, poll_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BYTE_W-1:0]  dev_reg, dev_next;
    logic [BYTE_W-1:0]  regaddr_reg, regaddr_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic               is_read_reg, is_read_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               drive_reg, drive_next;
    logic [1:0]         stage_reg, stage_next;
    logic               fail_reg, fail_next;
    logic [BYTE_W-1:0]  last_reg, last_next;
    logic               done_reg, done_next;
    logic               m_valid_reg;

    logic               step_en;
    logic               start;
    logic               run;
    logic               hold_en;
    logic [2:0]         hold_n;
    logic [DELAY_W-1:0] hold_prod;
    logic [DELAY_W-1:0] hold_val;
    phase_t             ack_target;

    assign cfg_ready = 1'b1;
    assign step_en   = q_valid && (!m_valid_reg || m_ready);
    assign q_pop     = step_en;
    assign start     = (phase_reg == PH_IDLE) && (q_word.kind != KIND_NONE);
    assign run       = (phase_reg != PH_IDLE) && (delay_reg == '0);

    assign hold_prod = DELAY_W'(hold_n) * DELAY_W'(unit_reg);
    assign hold_val  = (hold_prod == '0) ? '0 : hold_prod - DELAY_W'(1);

    always_comb begin
        case (stage_reg)
            2'd0:    ack_target = PH_TXB;
            2'd1:    ack_target = is_read_reg ? PH_ST0 : PH_TXB;
            default: ack_target = is_read_reg ? PH_RREL : PH_SP0;
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (phase_reg == PH_IDLE) begin
            if (start) begin
                phase_next = PH_ST1;
            end
        end else if (run) begin
            case (phase_reg)
                PH_ST0:   phase_next = PH_ST1;
                PH_ST1:   phase_next = PH_ST2;
                PH_ST2:   phase_next = PH_ST3;
                PH_ST3:   phase_next = PH_ST4;
                PH_ST4:   phase_next = PH_TXB;
                PH_TXB:   phase_next = PH_TXH;
                PH_TXH:   phase_next = PH_TXL;
                PH_TXL:   phase_next = (bit_reg == 3'd0) ? PH_AREL : PH_TXB;
                PH_AREL:  phase_next = PH_AHI;
                PH_AHI:   phase_next = PH_ASMP;
                PH_ASMP: begin
                    if (!q_word.sda_in) begin
                        phase_next = ack_target;
                    end else if (poll_reg == RETRY_W'(1)) begin
                        phase_next = PH_AGIVE;
                    end
                end
                PH_AGIVE: phase_next = PH_ABORT;
                PH_RREL:  phase_next = PH_RHI;
                PH_RHI:   phase_next = PH_RSMP;
                PH_RSMP:  phase_next = PH_RLO;
                PH_RLO:   phase_next = (bit_reg != 3'd0) ? PH_RHI : PH_NHI;
                PH_NHI:   phase_next = PH_NLO;
                PH_NLO:   phase_next = PH_SP0;
                PH_SP0:   phase_next = PH_SP1;
                PH_SP1:   phase_next = PH_SP2;
                PH_SP2:   phase_next = PH_SP3;
                PH_SP3:   phase_next = PH_SP4;
                PH_SP4:   phase_next = PH_ENDOK;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // line levels, counters and data
    always_comb begin
        bit_next     = bit_reg;
        delay_next   = delay_reg;
        poll_next    = poll_reg;
        shift_next   = shift_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        data_next    = data_reg;
        is_read_next = is_read_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        drive_next   = drive_reg;
        stage_next   = stage_reg;
        fail_next    = fail_reg;
        last_next    = last_reg;
        done_next    = 1'b0;
        hold_en      = 1'b0;
        hold_n       = 3'd0;
        if (phase_reg == PH_IDLE) begin
            if (start) begin
                dev_next     = q_word.device_addr;
                regaddr_next = q_word.register_addr;
                data_next    = q_word.write_data;
                is_read_next = (q_word.kind == KIND_READ);
                fail_next    = 1'b0;
                stage_next   = 2'd0;
                bit_next     = 3'd7;
                shift_next   = q_word.device_addr;
                scl_next     = 1'b0;
                drive_next   = 1'b1;
                hold_en      = 1'b1;
                hold_n       = 3'd1;
            end
        end else if (!run) begin
            delay_next = delay_reg - DELAY_W'(1);
        end else begin
            hold_en = 1'b1;
            case (phase_reg)
                PH_ST0: begin
                    scl_next = 1'b0; drive_next = 1'b1; hold_n = 3'd1;
                end
                PH_ST1: begin
                    sda_next = 1'b1; hold_n = 3'd1;
                end
                PH_ST2: begin
                    scl_next = 1'b1; hold_n = 3'd5;
                end
                PH_ST3: begin
                    sda_next = 1'b0; hold_n = 3'd5;
                end
                PH_ST4: begin
                    scl_next = 1'b0; hold_n = 3'd2;
                end
                PH_TXB: begin
                    drive_next = 1'b1; sda_next = shift_reg[bit_reg]; hold_n = 3'd1;
                end
                PH_TXH: begin
                    scl_next = 1'b1; hold_n = 3'd5;
                end
                PH_TXL: begin
                    scl_next = 1'b0; hold_n = 3'd1;
                    if (bit_reg != 3'd0) begin
                        bit_next = bit_reg - 3'd1;
                    end
                end
                PH_AREL: begin
                    sda_next = 1'b1; drive_next = 1'b0; hold_n = 3'd3;
                end
                PH_AHI: begin
                    scl_next = 1'b1; hold_n = 3'd5; poll_next = retries_reg;
                end
                PH_ASMP: begin
                    if (!q_word.sda_in) begin
                        scl_next   = 1'b0;
                        hold_n     = 3'd3;
                        bit_next   = 3'd7;
                        stage_next = stage_reg + 2'd1;
                        if (stage_reg == 2'd0) begin
                            shift_next = regaddr_reg;
                        end else if (stage_reg == 2'd1) begin
                            shift_next = is_read_reg ? dev_reg + BYTE_W'(1) : data_reg;
                        end
                    end else begin
                        hold_n    = 3'd1;
                        poll_next = poll_reg - RETRY_W'(1);
                    end
                end
                PH_AGIVE: begin
                    scl_next = 1'b0; hold_n = 3'd3;
                end
                PH_RREL: begin
                    drive_next = 1'b0; shift_next = '0; hold_n = 3'd5;
                end
                PH_RHI: begin
                    scl_next = 1'b1; hold_n = 3'd3;
                end
                PH_RSMP: begin
                    shift_next = shift_reg | (BYTE_W'(q_word.sda_in) << bit_reg);
                    hold_n     = 3'd3;
                end
                PH_RLO: begin
                    scl_next = 1'b0;
                    if (bit_reg != 3'd0) begin
                        bit_next = bit_reg - 3'd1; hold_n = 3'd5;
                    end else begin
                        drive_next = 1'b1; sda_next = 1'b1; hold_n = 3'd3;
                    end
                end
                PH_NHI: begin
                    scl_next = 1'b1; hold_n = 3'd5;
                end
                PH_NLO: begin
                    scl_next = 1'b0; hold_n = 3'd2;
                end
                PH_SP0: begin
                    scl_next = 1'b0; drive_next = 1'b1; hold_n = 3'd1;
                end
                PH_SP1: begin
                    sda_next = 1'b0; hold_n = 3'd1;
                end
                PH_SP2: begin
                    scl_next = 1'b1; hold_n = 3'd5;
                end
                PH_SP3: begin
                    sda_next = 1'b1; hold_n = 3'd5;
                end
                PH_SP4: begin
                    scl_next = 1'b0; hold_n = 3'd2;
                end
                PH_ENDOK: begin
                    hold_en   = 1'b0;
                    done_next = 1'b1;
                    if (is_read_reg) begin
                        last_next = shift_reg;
                    end
                end
                PH_ABORT: begin
                    hold_en   = 1'b0;
                    done_next = 1'b1;
                    fail_next = 1'b1;
                end
                default: begin
                    hold_en   = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
        if (hold_en) begin
            delay_next = hold_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg    <= UNIT_TICKS_RESET;
            retries_reg <= ACK_RETRIES_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_UNIT_TICKS) begin
                unit_reg <= cfg_data;
            end else if (cfg_index == CFG_ACK_RETRIES) begin
                retries_reg <= cfg_data[RETRY_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            bit_reg     <= 3'd7;
            delay_reg   <= '0;
            poll_reg    <= '0;
            shift_reg   <= '0;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            data_reg    <= '0;
            is_read_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drive_reg   <= 1'b0;
            stage_reg   <= 2'd0;
            fail_reg    <= 1'b0;
            last_reg    <= '0;
            done_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            delay_reg   <= delay_next;
            poll_reg    <= poll_next;
            shift_reg   <= shift_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            data_reg    <= data_next;
            is_read_reg <= is_read_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            drive_reg   <= drive_next;
            stage_reg   <= stage_next;
            fail_reg    <= fail_next;
            last_reg    <= last_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // state registers only move on step_en, so they double as the result word
    assign m_valid     = m_valid_reg;
    assign m_scl_out   = scl_reg;
    assign m_sda_out   = sda_reg;
    assign m_sda_drive = drive_reg;
    assign m_busy_res  = (phase_reg != PH_IDLE);
    assign m_done_res  = done_reg;
    assign m_ack_fail  = fail_reg;
    assign m_read_data = last_reg;

endmodule
